/* rtl/lst_pkg.sv */
package lst_pkg;

   localparam int SLOTS   = 16;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int ID_W    = 64;
   localparam int TIME_W  = 32;
   localparam int LEASE_W = 20;

   localparam logic [LEASE_W-1:0] LEASE_RESET = LEASE_W'(30000);
   localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(SLOTS - 1);

   localparam logic [3:0] FLAG_BUFFER    = 4'b0001;
   localparam logic [3:0] FLAG_RENDERING = 4'b0010;
   localparam logic [3:0] FLAG_HISTORY   = 4'b0100;
   localparam logic [3:0] FLAG_EFFECTS   = 4'b1000;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_ALLOCATE  = 3'd1,
      CMD_RELEASE   = 3'd2,
      CMD_EFFECTS   = 3'd3,
      CMD_RENDERING = 3'd4,
      CMD_HISTORY   = 3'd5,
      CMD_RENEW     = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] expiry;
      logic [3:0]        typ;
      logic [3:0]        flags;
   } slot_rec_type;

   // what the scanner compares each entry against
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [3:0]        need;
      logic              id_only;
      logic [TIME_W-1:0] now;
   } scan_cfg_type;

   typedef struct packed {
      logic              match_hit;
      logic [IDX_W-1:0]  match_idx;
      slot_rec_type      match_rec;
      logic              free_hit;
      logic [IDX_W-1:0]  free_idx;
   } scan_res_type;

endpackage

/* rtl/lst_ram.sv */
module lst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/lst_scan.sv */
module lst_scan import lst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             ent_vld,
   input  logic [IDX_W-1:0] ent_idx,
   input  slot_rec_type     ent_rec,
   input  scan_cfg_type     cfg,
   output scan_res_type     res
);

   logic              match_hit_ff, match_hit_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   slot_rec_type      match_rec_ff, match_rec_in;
   logic              free_hit_ff, free_hit_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [TIME_W-1:0] free_exp_ff, free_exp_in;

   logic is_match;
   logic is_free;

   always_comb begin
      is_match = (ent_rec.id == cfg.id) &&
                 (cfg.id_only || ((ent_rec.flags & (FLAG_BUFFER | cfg.need)) != 4'b0000));
      is_free  = (ent_rec.expiry <= cfg.now);

      match_hit_in = match_hit_ff;
      match_idx_in = match_idx_ff;
      match_rec_in = match_rec_ff;
      free_hit_in  = free_hit_ff;
      free_idx_in  = free_idx_ff;
      free_exp_in  = free_exp_ff;

      if (clear) begin
         match_hit_in = 1'b0;
         free_hit_in  = 1'b0;
      end else if (ent_vld) begin
         // first match wins
         if (is_match && !match_hit_ff) begin
            match_hit_in = 1'b1;
            match_idx_in = ent_idx;
            match_rec_in = ent_rec;
         end
         // strictly smaller expiry replaces, so ties keep the lower index
         if (is_free && (!free_hit_ff || (ent_rec.expiry < free_exp_ff))) begin
            free_hit_in = 1'b1;
            free_idx_in = ent_idx;
            free_exp_in = ent_rec.expiry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_hit_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
      end else begin
         match_hit_ff <= match_hit_in;
         free_hit_ff  <= free_hit_in;
      end
      match_idx_ff <= match_idx_in;
      match_rec_ff <= match_rec_in;
      free_idx_ff  <= free_idx_in;
      free_exp_ff  <= free_exp_in;
   end

   assign res = '{match_hit: match_hit_ff, match_idx: match_idx_ff, match_rec: match_rec_ff,
                  free_hit: free_hit_ff, free_idx: free_idx_ff};

endmodule

/* rtl/lease_slot_table.sv */
// Table commands read every slot in turn, then pass a drain state and a write-back
//   state that registers the response; tick and unknown commands go to write-back.
// Write-back waits while the response register is full. Requests are taken only in
//   idle, one at a time; the single memory read port is swept once per table command.
// Reset: synchronous, active high; clears slot valid bits, time and the response
//   valid flag, loads lease_ticks with 30000; no clearing pass.
module lease_slot_table import lst_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   // [63:0] entry_id, [67:64] entry_type, [68] carries_buffer, [84:69] elapsed
   input  logic [87:0]        req_tdata,
   // [2:0] command
   input  logic [2:0]         req_tuser,
   // response channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [3:0] slot, [4] has_buffer, [5] has_rendering, [6] has_history,
   // [7] has_effects, [11:8] slot_type
   output logic [15:0]        rsp_tdata,
   // [0] ok
   output logic               rsp_tuser,
   // lease_ticks register
   input  logic               csr_wen,
   input  logic [LEASE_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------
   // control and request registers
   // ---------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   cmd_type           cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [3:0]        etype_ff;
   logic              buf_ff;
   logic [15:0]       elapsed_ff;
   logic [TIME_W-1:0] lease_end_ff, lease_end_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [LEASE_W-1:0] lease_ticks_ff;
   logic [SLOTS-1:0]  valid_ff;
   logic              rsp_valid_ff;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              go;
   logic [TIME_W:0]   lease_sum;
   logic [TIME_W:0]   tick_sum;

   // memory ports
   logic              ram_re;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   slot_rec_type      ram_wrec;
   slot_rec_type      ram_q;
   slot_rec_type      ent_rec;

   scan_cfg_type      scan_cfg;
   scan_res_type      scan_res;

   logic [3:0]        attach_flag;
   logic              hit;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   // write back only once the response register can take the result
   assign go         = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_tready);

   // lease end taken at accept; time holds while busy; lease_ticks is not held by the block
   assign lease_sum    = {1'b0, time_ff} + (TIME_W + 1)'(lease_ticks_ff);
   assign lease_end_in = lease_sum[TIME_W] ? '1 : lease_sum[TIME_W-1:0];
   assign tick_sum     = {1'b0, time_ff} + (TIME_W + 1)'(elapsed_ff);

   // ---------------------------------------------------------------
   // slot memory: one record per slot, valid bit masks unwritten slots to zero
   // ---------------------------------------------------------------
   lst_ram #(
      .WIDTH($bits(slot_rec_type)),
      .DEPTH(SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wrec),
      .re    (ram_re),
      .raddr (addr_ff),
      .rdata (ram_q)
   );

   assign ent_rec = valid_ff[rd_idx_ff] ? ram_q : '0;

   // ---------------------------------------------------------------
   // scanner: first id match (flag-qualified unless release) and oldest free slot
   // ---------------------------------------------------------------
   always_comb begin
      case (cmd_ff)
         CMD_EFFECTS:   attach_flag = FLAG_EFFECTS;
         CMD_RENDERING: attach_flag = FLAG_RENDERING;
         CMD_HISTORY:   attach_flag = FLAG_HISTORY;
         CMD_RENEW:     attach_flag = FLAG_RENDERING;
         default:       attach_flag = 4'b0000;
      endcase
   end

   assign scan_cfg = '{id: id_ff, need: attach_flag, id_only: (cmd_ff == CMD_RELEASE),
                       now: time_ff};

   lst_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept),
      .ent_vld (rd_vld_ff),
      .ent_idx (rd_idx_ff),
      .ent_rec (ent_rec),
      .cfg     (scan_cfg),
      .res     (scan_res)
   );

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // tick and unknown commands do not touch the table
               if ((req_tuser == 3'(CMD_TICK)) || (req_tuser > 3'(CMD_RENEW))) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // outputs: read sweep, write-back and response
   // ---------------------------------------------------------------
   always_comb begin
      ram_re      = (state_ff == ST_SCAN);
      addr_in     = (state_ff == ST_SCAN) ? addr_ff + IDX_W'(1) : '0;
      hit         = 1'b0;
      ram_waddr   = scan_res.match_idx;
      ram_wrec    = scan_res.match_rec;
      time_in     = time_ff;
      rsp_ok_in   = 1'b0;

      case (cmd_ff)
         CMD_TICK: begin
            time_in   = tick_sum[TIME_W] ? '1 : tick_sum[TIME_W-1:0];
            rsp_ok_in = 1'b1;
         end
         CMD_ALLOCATE: begin
            hit       = scan_res.free_hit;
            ram_waddr = scan_res.free_idx;
            ram_wrec  = '{id: id_ff, expiry: lease_end_ff, typ: etype_ff,
                          flags: buf_ff ? FLAG_BUFFER : 4'b0000};
         end
         CMD_RELEASE: begin
            hit             = scan_res.match_hit;
            ram_wrec.expiry = '0;
            ram_wrec.typ    = 4'b0000;
         end
         CMD_EFFECTS, CMD_RENDERING, CMD_HISTORY: begin
            if (scan_res.match_hit) begin
               hit             = 1'b1;
               ram_wrec.flags  = scan_res.match_rec.flags | attach_flag;
               ram_wrec.expiry = lease_end_ff;
            end else begin
               // miss: fresh slot, no type, no buffer, only the attach flag
               hit       = scan_res.free_hit;
               ram_waddr = scan_res.free_idx;
               ram_wrec  = '{id: id_ff, expiry: lease_end_ff, typ: 4'b0000,
                             flags: attach_flag};
            end
         end
         CMD_RENEW: begin
            hit             = scan_res.match_hit;
            ram_wrec.expiry = lease_end_ff;
         end
         default: hit = 1'b0;
      endcase

      if (hit) begin
         rsp_ok_in   = 1'b1;
         rsp_data_in = {4'b0000, ram_wrec.typ, ram_wrec.flags, 4'(ram_waddr)};
      end else begin
         rsp_data_in = '0;
      end

      ram_we = go && hit;
      if (!go) begin
         time_in = time_ff;
      end
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_vld_ff      <= 1'b0;
         time_ff        <= '0;
         lease_ticks_ff <= LEASE_RESET;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= ram_re;
         time_ff   <= time_in;
         if (csr_wen) begin
            lease_ticks_ff <= csr_wdata;
         end
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      addr_ff   <= addr_in;
      rd_idx_ff <= addr_ff;
      if (accept) begin
         cmd_ff       <= cmd_type'(req_tuser);
         id_ff        <= req_tdata[63:0];
         etype_ff     <= req_tdata[67:64];
         buf_ff       <= req_tdata[68];
         elapsed_ff   <= req_tdata[84:69];
         lease_end_ff <= lease_end_in;
      end
      if (go) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_tick_skips_scan: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == 3'(CMD_TICK)) |=> (state_ff == ST_DECIDE))
      else $error("tick transaction entered the slot sweep");

   a_write_in_decide: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_DECIDE) && !rd_vld_ff)
      else $error("slot write outside the write-back cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == 16'h0000))
      else $error("failed response carries nonzero fields");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (time_ff >= $past(time_ff)))
      else $error("current time went backwards");

endmodule
